// File: design/request_framer_text_normalizer_assert.svh
// ----------------------------------------------------------------------------
// request_framer_text_normalizer_assert.svh
// Assertion macros used by the checker file of the request framer.
// ----------------------------------------------------------------------------
`ifndef REQUEST_FRAMER_TEXT_NORMALIZER_ASSERT_SVH
`define REQUEST_FRAMER_TEXT_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RFTN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RFTN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rftn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rftn_pkg
// Types, codes and character helpers for the request framer.
// ----------------------------------------------------------------------------
package rftn_pkg;

    localparam int HEADER_BYTES_DEF = 32;
    localparam int MAX_PAYLOAD_DEF  = 4096;

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [1:0] OP_DATA     = 2'd0;
    localparam logic [1:0] OP_CLOSE    = 2'd1;
    localparam logic [1:0] OP_DEADLINE = 2'd2;
    localparam logic [1:0] OP_CONNECT  = 2'd3;

    localparam logic [2:0] RC_OK_STATUS    = 3'd0;
    localparam logic [2:0] RC_OK_NORMALIZE = 3'd1;
    localparam logic [2:0] RC_TIMEOUT      = 3'd2;
    localparam logic [2:0] RC_FRAME        = 3'd3;
    localparam logic [2:0] RC_LIMIT        = 3'd4;
    localparam logic [2:0] RC_COMMAND      = 3'd5;
    localparam logic [2:0] RC_TEXT         = 3'd6;
    localparam logic [2:0] RC_EXHAUSTED    = 3'd7;

    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [4:0] {
        PH_HEADER        = 5'b00001,
        PH_PAYLOAD       = 5'b00010,
        PH_END_STATUS    = 5'b00100,
        PH_END_NORMALIZE = 5'b01000,
        PH_DONE          = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_FRAME = 2'd1,
        PEND_LIMIT = 2'd2
    } t_pend;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text;
        logic [2:0]  code;
        logic [63:0] count;
        logic [12:0] len;
        logic        last;
    } t_result;

    // results produced by one input beat, r0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic [7:0] status_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = "S";
            3'd1:    ch = "T";
            3'd2:    ch = "A";
            3'd3:    ch = "T";
            3'd4:    ch = "U";
            3'd5:    ch = "S";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] normalize_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "N";
            4'd1:    ch = "O";
            4'd2:    ch = "R";
            4'd3:    ch = "M";
            4'd4:    ch = "A";
            4'd5:    ch = "L";
            4'd6:    ch = "I";
            4'd7:    ch = "Z";
            4'd8:    ch = "E";
            4'd9:    ch = " ";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// File: design/rftn_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rftn_parser
// Connection state, header parse and payload normalization, one beat a cycle while i_accept is high.
// ----------------------------------------------------------------------------
module rftn_parser #(
    parameter int HEADER_BYTES = rftn_pkg::HEADER_BYTES_DEF,
    parameter int MAX_PAYLOAD  = rftn_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [1:0]      i_opcode,
    input  logic [7:0]      i_data_byte,
    output rftn_pkg::t_push o_push
);

    localparam int HL_W  = $clog2(HEADER_BYTES);
    // a maximum below nine lets digits above it bypass the limit test; the count
    // then grows freely in 32 bits
    localparam int PL_W  = (MAX_PAYLOAD >= 9) ? $clog2(MAX_PAYLOAD + 1) : 32;
    localparam int PR_W  = (PL_W > 13) ? PL_W : 13;
    localparam int ACC_W = PL_W + 5;

    rftn_pkg::t_phase r_phase, n_phase;
    rftn_pkg::t_pend  r_pend, n_pend;
    logic [HL_W-1:0]  r_hlen, n_hlen;
    logic             r_st_ok, n_st_ok;
    logic             r_nm_ok, n_nm_ok;
    logic             r_digit, n_digit;
    logic [PL_W-1:0]  r_plen, n_plen;
    logic [PL_W-1:0]  r_prcv, n_prcv;
    logic [PR_W-1:0]  r_prod, n_prod;
    logic             r_space, n_space;
    logic             r_bad, n_bad;
    logic [63:0]      r_succ, n_succ;

    function automatic rftn_pkg::t_result mk_reply(input logic [2:0] code,
                                                   input logic [63:0] cnt,
                                                   input logic [12:0] len);
        rftn_pkg::t_result r;
        r.kind  = rftn_pkg::KIND_REPLY;
        r.text  = 8'h00;
        r.code  = code;
        r.count = cnt;
        r.len   = len;
        r.last  = 1'b1;
        return r;
    endfunction

    function automatic rftn_pkg::t_result mk_text(input logic [7:0] b, input logic last);
        rftn_pkg::t_result r;
        r       = '0;
        r.kind  = rftn_pkg::KIND_TEXT;
        r.text  = b;
        r.last  = last;
        return r;
    endfunction

    logic [7:0]       c;
    logic [7:0]       dig8;
    logic             is_digit;
    logic [ACC_W-1:0] acc;
    logic             over;
    logic [PL_W-1:0]  rcv_inc;
    logic [7:0]       lower;

    assign c        = i_data_byte;
    assign dig8     = c - rftn_pkg::CH_ZERO;
    assign is_digit = (dig8 <= 8'd9);
    assign acc      = ({5'd0, r_plen} << 3) + ({5'd0, r_plen} << 1)
                      + ACC_W'(dig8[3:0]);
    assign over     = (32'(dig8[3:0]) <= 32'(MAX_PAYLOAD))
                      && (acc > ACC_W'(MAX_PAYLOAD));
    assign rcv_inc  = r_prcv + PL_W'(1);
    assign lower    = (c >= "A" && c <= "Z") ? (c + 8'd32) : c;

    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_hlen  = r_hlen;
        n_st_ok = r_st_ok;
        n_nm_ok = r_nm_ok;
        n_digit = r_digit;
        n_plen  = r_plen;
        n_prcv  = r_prcv;
        n_prod  = r_prod;
        n_space = r_space;
        n_bad   = r_bad;
        n_succ  = r_succ;
        o_push  = '0;

        if (i_accept) begin
            if (i_opcode == rftn_pkg::OP_CONNECT) begin
                n_phase = rftn_pkg::PH_HEADER;
                n_pend  = rftn_pkg::PEND_NONE;
                n_hlen  = '0;
                n_st_ok = 1'b1;
                n_nm_ok = 1'b1;
                n_digit = 1'b0;
                n_plen  = '0;
                n_prcv  = '0;
                n_prod  = '0;
                n_space = 1'b0;
                n_bad   = 1'b0;
            end else if (r_phase != rftn_pkg::PH_DONE) begin
                o_push.cnt = 2'd1;
                n_phase    = rftn_pkg::PH_DONE;
                priority if (i_opcode == rftn_pkg::OP_DEADLINE) begin
                    o_push.r0 = mk_reply(rftn_pkg::RC_TIMEOUT, r_succ, 13'd0);
                end else if (i_opcode == rftn_pkg::OP_CLOSE) begin
                    priority if (r_phase == rftn_pkg::PH_END_STATUS) begin
                        o_push.r0 = mk_reply(rftn_pkg::RC_OK_STATUS, r_succ, 13'd0);
                    end else if (r_phase == rftn_pkg::PH_END_NORMALIZE) begin
                        priority if (r_bad) begin
                            o_push.r0 = mk_reply(rftn_pkg::RC_TEXT, r_succ, 13'd0);
                        end else if (&r_succ) begin
                            o_push.r0 = mk_reply(rftn_pkg::RC_EXHAUSTED, r_succ, 13'd0);
                        end else begin
                            n_succ    = r_succ + 64'd1;
                            o_push.r0 = mk_reply(rftn_pkg::RC_OK_NORMALIZE, n_succ,
                                                 r_prod[12:0]);
                        end
                    end else begin
                        o_push.r0 = mk_reply(rftn_pkg::RC_FRAME, r_succ, 13'd0);
                    end
                end else if (r_phase == rftn_pkg::PH_HEADER) begin
                    // header byte: gives no result unless it ends the request with a reply
                    o_push.cnt = 2'd0;
                    n_phase    = r_phase;
                    if (c == rftn_pkg::CH_NL) begin
                        priority if (r_st_ok && r_hlen == HL_W'(6)) begin
                            n_phase = rftn_pkg::PH_END_STATUS;
                        end else if (r_nm_ok && r_digit) begin
                            priority if (r_pend == rftn_pkg::PEND_FRAME) begin
                                o_push.cnt = 2'd1;
                                o_push.r0  = mk_reply(rftn_pkg::RC_FRAME, r_succ, 13'd0);
                                n_phase    = rftn_pkg::PH_DONE;
                            end else if (r_pend == rftn_pkg::PEND_LIMIT) begin
                                o_push.cnt = 2'd1;
                                o_push.r0  = mk_reply(rftn_pkg::RC_LIMIT, r_succ, 13'd0);
                                n_phase    = rftn_pkg::PH_DONE;
                            end else begin
                                n_phase = (r_plen != '0) ? rftn_pkg::PH_PAYLOAD
                                                         : rftn_pkg::PH_END_NORMALIZE;
                            end
                        end else begin
                            o_push.cnt = 2'd1;
                            o_push.r0  = mk_reply(rftn_pkg::RC_COMMAND, r_succ, 13'd0);
                            n_phase    = rftn_pkg::PH_DONE;
                        end
                    end else if (r_hlen >= HL_W'(HEADER_BYTES - 1)) begin
                        o_push.cnt = 2'd1;
                        o_push.r0  = mk_reply(rftn_pkg::RC_LIMIT, r_succ, 13'd0);
                        n_phase    = rftn_pkg::PH_DONE;
                    end else if (c < rftn_pkg::CH_SPACE || c > rftn_pkg::CH_TILDE) begin
                        o_push.cnt = 2'd1;
                        o_push.r0  = mk_reply(rftn_pkg::RC_FRAME, r_succ, 13'd0);
                        n_phase    = rftn_pkg::PH_DONE;
                    end else begin
                        if (!(r_hlen < HL_W'(6) && c == rftn_pkg::status_char(r_hlen[2:0])))
                            n_st_ok = 1'b0;
                        if (r_hlen < HL_W'(10)) begin
                            if (c != rftn_pkg::normalize_char(r_hlen[3:0]))
                                n_nm_ok = 1'b0;
                        end else if (r_nm_ok) begin
                            n_digit = 1'b1;
                            if (r_pend == rftn_pkg::PEND_NONE) begin
                                priority if (!is_digit) begin
                                    n_pend = rftn_pkg::PEND_FRAME;
                                end else if (over) begin
                                    n_pend = rftn_pkg::PEND_LIMIT;
                                end else begin
                                    n_plen = acc[PL_W-1:0];
                                end
                            end
                        end
                        n_hlen = r_hlen + HL_W'(1);
                    end
                end else if (r_phase == rftn_pkg::PH_PAYLOAD) begin
                    o_push.cnt = 2'd0;
                    n_prcv     = rcv_inc;
                    n_phase    = (rcv_inc >= r_plen) ? rftn_pkg::PH_END_NORMALIZE
                                                     : rftn_pkg::PH_PAYLOAD;
                    if (!r_bad) begin
                        priority if (rftn_pkg::is_white(c)) begin
                            if (r_prod != '0)
                                n_space = 1'b1;
                        end else if (c < rftn_pkg::CH_SPACE || c == rftn_pkg::CH_DEL) begin
                            n_bad = 1'b1;
                        end else if (r_space) begin
                            // held-back separator goes out ahead of the byte
                            o_push.cnt = 2'd2;
                            o_push.r0  = mk_text(rftn_pkg::CH_SPACE, 1'b0);
                            o_push.r1  = mk_text(lower, 1'b1);
                            n_prod     = r_prod + PR_W'(2);
                            n_space    = 1'b0;
                        end else begin
                            o_push.cnt = 2'd1;
                            o_push.r0  = mk_text(lower, 1'b1);
                            n_prod     = r_prod + PR_W'(1);
                        end
                    end
                end else begin
                    // data after a complete request
                    o_push.r0 = mk_reply(rftn_pkg::RC_FRAME, r_succ, 13'd0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rftn_pkg::PH_HEADER;
            r_pend  <= rftn_pkg::PEND_NONE;
            r_hlen  <= '0;
            r_st_ok <= 1'b1;
            r_nm_ok <= 1'b1;
            r_digit <= 1'b0;
            r_plen  <= '0;
            r_prcv  <= '0;
            r_prod  <= '0;
            r_space <= 1'b0;
            r_bad   <= 1'b0;
            r_succ  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_hlen  <= n_hlen;
            r_st_ok <= n_st_ok;
            r_nm_ok <= n_nm_ok;
            r_digit <= n_digit;
            r_plen  <= n_plen;
            r_prcv  <= n_prcv;
            r_prod  <= n_prod;
            r_space <= n_space;
            r_bad   <= n_bad;
            r_succ  <= n_succ;
        end
    end

endmodule

// File: design/rftn_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rftn_outq
// Result queue: takes up to two results a cycle, hands out one a cycle while i_pop is high.
// ----------------------------------------------------------------------------
module rftn_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rftn_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output rftn_pkg::t_result o_head
);

    rftn_pkg::t_result r_mem [rftn_pkg::OUTQ_DEPTH];

    logic [rftn_pkg::OUTQ_AW-1:0] r_wr, n_wr;
    logic [rftn_pkg::OUTQ_AW-1:0] r_rd, n_rd;
    logic [rftn_pkg::OUTQ_CW-1:0] r_cnt, n_cnt;
    logic [rftn_pkg::OUTQ_AW-1:0] wr_nxt;

    // room must be left for a two-result beat
    assign o_full  = (r_cnt > rftn_pkg::OUTQ_CW'(rftn_pkg::OUTQ_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign wr_nxt  = r_wr + rftn_pkg::OUTQ_AW'(1);

    always_comb begin
        n_wr  = r_wr + rftn_pkg::OUTQ_AW'(i_push.cnt);
        n_rd  = r_rd + rftn_pkg::OUTQ_AW'(i_pop);
        n_cnt = r_cnt + rftn_pkg::OUTQ_CW'(i_push.cnt) - rftn_pkg::OUTQ_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0)
            r_mem[r_wr] <= i_push.r0;
        if (i_push.cnt == 2'd2)
            r_mem[wr_nxt] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: design/request_framer_text_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_framer_text_normalizer
// Per-connection request framer with streaming text normalization.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one beat per cycle: an opcode
//   (data byte, peer close, deadline, new connection) and a data byte.
//   Output channel (o_valid / i_stall) carries normalized text bytes and the
//   final reply; o_last_item marks the last result caused by an input beat.
//   Throughput is one input beat per cycle while o_stall is low. A payload
//   byte that follows a collapsed whitespace run causes two results (space,
//   then byte); the four-entry result queue absorbs the extra result.
//   An accepted beat's results are written into the result queue.
//   o_stall rises when the queue cannot take a two-result beat, so under
//   sustained i_stall the input side stops after at most four results wait.
//   Reset (synchronous, active low) empties the queue, clears the success
//   counter and leaves the block as if a new connection had just opened.
//   Consumers drop streamed text when the final reply is an error.
// ----------------------------------------------------------------------------
module request_framer_text_normalizer #(
    parameter int HEADER_BYTES = rftn_pkg::HEADER_BYTES_DEF,
    parameter int MAX_PAYLOAD  = rftn_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_item_kind,
    output logic [7:0]  o_text_byte,
    output logic [2:0]  o_reply_code,
    output logic [63:0] o_completed_count,
    output logic [12:0] o_output_length,
    output logic        o_last_item
);

    logic              in_accept;
    logic              q_full;
    logic              out_pop;
    rftn_pkg::t_push   push;
    rftn_pkg::t_result head;

    // stall comes from registered queue fill only, never from i_valid
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;
    assign out_pop   = o_valid && !i_stall;

    rftn_parser #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .o_push      (push)
    );

    rftn_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_full  (q_full),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_item_kind       = head.kind;
    assign o_text_byte       = head.text;
    assign o_reply_code      = head.code;
    assign o_completed_count = head.count;
    assign o_output_length   = head.len;
    assign o_last_item       = head.last;

endmodule

// File: design/rftn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rftn_checker
// Port-level checks on the request framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "request_framer_text_normalizer_assert.svh"

module rftn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_item_kind,
    input logic [7:0]  o_text_byte,
    input logic [2:0]  o_reply_code,
    input logic [63:0] o_completed_count,
    input logic [12:0] o_output_length,
    input logic        o_last_item
);

    `RFTN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable({o_item_kind, o_text_byte, o_reply_code, o_completed_count, o_output_length, o_last_item}), "stalled beat changed")

    `RFTN_ASSERT_NOW(a_text_clean, i_clk, i_rst_n, o_valid && o_item_kind == rftn_pkg::KIND_TEXT, o_reply_code == 3'd0 && o_completed_count == 64'd0 && o_output_length == 13'd0, "text beat carries reply fields")

    `RFTN_ASSERT_NOW(a_reply_last, i_clk, i_rst_n, o_valid && o_item_kind == rftn_pkg::KIND_REPLY, o_last_item && o_text_byte == 8'h00, "final reply not marked last")

    `RFTN_ASSERT_NOW(a_len_ok_only, i_clk, i_rst_n, o_valid && o_output_length != 13'd0, o_item_kind == rftn_pkg::KIND_REPLY && o_reply_code == rftn_pkg::RC_OK_NORMALIZE, "length on a non-normalize beat")

endmodule

bind request_framer_text_normalizer rftn_checker u_rftn_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_item_kind       (o_item_kind),
    .o_text_byte       (o_text_byte),
    .o_reply_code      (o_reply_code),
    .o_completed_count (o_completed_count),
    .o_output_length   (o_output_length),
    .o_last_item       (o_last_item)
);

// File: test/tb_request_framer_text_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_framer_text_normalizer
// Self-checking bench for the request framer with streaming normalization.
// A short table of hand-picked beats opens the run. It covers a deadline on a
// fresh connection, beats ignored after a reply, header bytes at both ends of
// the byte range, a newline after printable bytes, a close during the header and a clean
// STATUS request. Random sessions follow: mostly well-formed requests with
// random text, plus broken headers, truncated payloads and noise. The sessions
// run in four flow-control phases. A behavioral model of the parser predicts
// every text byte and untyped reply; the checker compares them in order.
// ----------------------------------------------------------------------------
module tb_request_framer_text_normalizer;
    import rftn_pkg::*;

    localparam int HDR_LIMIT       = HEADER_BYTES_DEF;
    localparam int PAYLOAD_MAX     = MAX_PAYLOAD_DEF;
    localparam int TARGET_BEATS    = 1050;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [47:0] STATUS_WORD    = "STATUS";
    localparam logic [79:0] NORMALIZE_WORD = "NORMALIZE ";
    localparam logic [7:0]  WS_CHARS [6]   = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};

    // one row of the directed table; typed rows carry their reply code
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] b;
        logic       typed;
        logic [2:0] code;
    } t_row;

    localparam int N_ROWS = 24;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{OP_DEADLINE, 8'h00,    1'b1, RC_TIMEOUT},    // deadline on a fresh link
        '{OP_DATA,     "A",      1'b0, RC_OK_STATUS},  // ignored after reply
        '{OP_CLOSE,    8'h00,    1'b0, RC_OK_STATUS},  // ignored after reply
        '{OP_CONNECT,  8'hFF,    1'b0, RC_OK_STATUS},
        '{OP_DATA,     8'h00,    1'b1, RC_FRAME},      // NUL in header
        '{OP_CONNECT,  8'h00,    1'b0, RC_OK_STATUS},
        '{OP_DATA,     8'hFF,    1'b1, RC_FRAME},      // top byte in header
        '{OP_CONNECT,  8'h00,    1'b0, RC_OK_STATUS},
        '{OP_DATA,     CH_TILDE, 1'b0, RC_OK_STATUS},  // highest printable
        '{OP_DATA,     CH_SPACE, 1'b0, RC_OK_STATUS},  // lowest printable
        '{OP_DATA,     CH_NL,    1'b1, RC_COMMAND},
        '{OP_CONNECT,  8'h00,    1'b0, RC_OK_STATUS},
        '{OP_CLOSE,    8'h00,    1'b1, RC_FRAME},      // close with no header
        '{OP_CONNECT,  8'h00,    1'b0, RC_OK_STATUS},
        '{OP_DATA,     "S",      1'b0, RC_OK_STATUS},
        '{OP_DATA,     "T",      1'b0, RC_OK_STATUS},
        '{OP_DATA,     "A",      1'b0, RC_OK_STATUS},
        '{OP_DATA,     "T",      1'b0, RC_OK_STATUS},
        '{OP_DATA,     "U",      1'b0, RC_OK_STATUS},
        '{OP_DATA,     "S",      1'b0, RC_OK_STATUS},
        '{OP_DATA,     CH_NL,    1'b0, RC_OK_STATUS},
        '{OP_CLOSE,    8'h00,    1'b1, RC_OK_STATUS},
        '{OP_CONNECT,  8'h00,    1'b0, RC_OK_STATUS},
        '{OP_DATA,     CH_DEL,   1'b1, RC_FRAME}       // DEL in header
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_item_kind;
    logic [7:0]  o_text_byte;
    logic [2:0]  o_reply_code;
    logic [63:0] o_completed_count;
    logic [12:0] o_output_length;
    logic        o_last_item;

    request_framer_text_normalizer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_data_byte       (i_data_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_item_kind       (o_item_kind),
        .o_text_byte       (o_text_byte),
        .o_reply_code      (o_reply_code),
        .o_completed_count (o_completed_count),
        .o_output_length   (o_output_length),
        .o_last_item       (o_last_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model state: a private copy of what the block tracks
    // ------------------------------------------------------------------
    t_phase      rq_phase;
    int          hdr_len;
    bit          may_status;
    bit          may_normalize;
    bit          digit_seen;
    t_pend       hdr_err;
    int          body_len;
    int          body_seen;
    int          text_len;
    bit          gap_pending;
    bit          bad_text;
    logic [63:0] ok_count;

    t_result     due_items [$];    // text bytes and replies still to arrive

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int beats_counted = 0;         // beats that the block did not ignore
    int mismatches    = 0;
    int quiet_cycles  = 0;

    function automatic void open_connection();
        rq_phase      = PH_HEADER;
        hdr_len       = 0;
        may_status    = 1'b1;
        may_normalize = 1'b1;
        digit_seen    = 1'b0;
        hdr_err       = PEND_NONE;
        body_len      = 0;
        body_seen     = 0;
        text_len      = 0;
        gap_pending   = 1'b0;
        bad_text      = 1'b0;
    endfunction

    // final reply closes the request; output_length only rides on ok normalize
    function automatic void push_reply(input logic [2:0] code);
        t_result r;
        r       = '0;
        r.kind  = KIND_REPLY;
        r.code  = code;
        r.count = ok_count;
        if (code == RC_OK_NORMALIZE) begin
            r.len = text_len[12:0];
        end
        r.last = 1'b1;
        due_items.push_back(r);
        rq_phase = PH_DONE;
    endfunction

    function automatic void push_text(input logic [7:0] b, input logic last);
        t_result r;
        r      = '0;
        r.kind = KIND_TEXT;
        r.text = b;
        r.last = last;
        due_items.push_back(r);
        text_len++;
    endfunction

    function automatic void header_byte(input logic [7:0] c);
        int d;
        if (c == CH_NL) begin
            if (may_status && hdr_len == 6) begin
                rq_phase = PH_END_STATUS;
            end else if (may_normalize && digit_seen) begin
                if (hdr_err == PEND_FRAME) begin
                    push_reply(RC_FRAME);
                end else if (hdr_err == PEND_LIMIT) begin
                    push_reply(RC_LIMIT);
                end else begin
                    rq_phase = (body_len > 0) ? PH_PAYLOAD : PH_END_NORMALIZE;
                end
            end else begin
                push_reply(RC_COMMAND);
            end
        end else if (hdr_len + 1 >= HDR_LIMIT) begin
            // length test wins over the character test
            push_reply(RC_LIMIT);
        end else if (c < CH_SPACE || c > CH_TILDE) begin
            push_reply(RC_FRAME);
        end else begin
            if (hdr_len < 6) begin
                if (c != STATUS_WORD[8*(5-hdr_len) +: 8]) may_status = 1'b0;
            end else begin
                may_status = 1'b0;
            end
            if (hdr_len < 10) begin
                if (c != NORMALIZE_WORD[8*(9-hdr_len) +: 8]) may_normalize = 1'b0;
            end else if (may_normalize) begin
                // first error from the left sticks until newline
                digit_seen = 1'b1;
                if (hdr_err == PEND_NONE) begin
                    d = int'(c) - int'(CH_ZERO);
                    if (d < 0 || d > 9) begin
                        hdr_err = PEND_FRAME;
                    end else if (body_len > (PAYLOAD_MAX - d) / 10) begin
                        hdr_err = PEND_LIMIT;
                    end else begin
                        body_len = body_len * 10 + d;
                    end
                end
            end
            hdr_len++;
        end
    endfunction

    function automatic void body_byte(input logic [7:0] c);
        body_seen++;
        if (body_seen >= body_len) rq_phase = PH_END_NORMALIZE;
        if (!bad_text) begin
            if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
                // leading whitespace is dropped, inner runs become one space
                if (text_len > 0) gap_pending = 1'b1;
            end else if (c < CH_SPACE || c == CH_DEL) begin
                bad_text = 1'b1;
            end else begin
                if (gap_pending) begin
                    push_text(CH_SPACE, 1'b0);
                    gap_pending = 1'b0;
                end
                push_text((c >= "A" && c <= "Z") ? c + 8'd32 : c, 1'b1);
            end
        end
    endfunction

    // returns 1 when the block ignores the beat
    function automatic bit parse_beat(input logic [1:0] op, input logic [7:0] c);
        if (op == OP_CONNECT) begin
            open_connection();
            return 1'b0;
        end
        if (rq_phase == PH_DONE) return 1'b1;
        if (op == OP_DEADLINE) begin
            push_reply(RC_TIMEOUT);
        end else if (op == OP_CLOSE) begin
            if (rq_phase == PH_END_STATUS) begin
                push_reply(RC_OK_STATUS);
            end else if (rq_phase == PH_END_NORMALIZE) begin
                if (bad_text) begin
                    push_reply(RC_TEXT);
                end else if (ok_count == '1) begin
                    push_reply(RC_EXHAUSTED);
                end else begin
                    ok_count++;
                    push_reply(RC_OK_NORMALIZE);
                end
            end else begin
                push_reply(RC_FRAME);
            end
        end else if (rq_phase == PH_HEADER) begin
            header_byte(c);
        end else if (rq_phase == PH_PAYLOAD) begin
            body_byte(c);
        end else begin
            push_reply(RC_FRAME);    // data after a complete request
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Input side: called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] op, input logic [7:0] b,
                             input logic typed = 1'b0,
                             input logic [2:0] code = RC_OK_STATUS);
        int      n0;
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        // beat accepted at this edge; its results can show up next edge at the earliest
        n0 = due_items.size();
        if (!parse_beat(op, b)) beats_counted++;
        if (typed) begin
            // table rows give the reply outright
            while (due_items.size() > n0) void'(due_items.pop_back());
            r      = '0;
            r.kind = KIND_REPLY;
            r.code = code;
            r.last = 1'b1;
            due_items.push_back(r);
        end
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++) send_beat(OP_DATA, s[k]);
    endtask

    function automatic string normalize_line(input int n, input int zeros);
        string s;
        s = "NORMALIZE ";
        repeat (zeros) s = {s, "0"};
        return {s, $sformatf("%0d", n), "\n"};
    endfunction

    // payload byte: letters, whitespace, punctuation, high bytes, rare controls
    function automatic logic [7:0] random_text_byte(input bit ctrl_ok);
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 45) return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
        if (r < 62) return WS_CHARS[$urandom_range(5)];
        if (r < 85) return 8'($urandom_range(8'h21, 8'h7E));
        if (r < 93 || !ctrl_ok) return 8'($urandom_range(8'h80, 8'hFF));
        if ($urandom_range(3) == 0) return CH_DEL;
        c = 8'($urandom_range(31));
        if (c >= 8'h09 && c <= 8'h0D) c = 8'h00;
        return c;
    endfunction

    // how a request ends: mostly a clean close
    task automatic end_session();
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            send_beat(OP_CLOSE, 8'($urandom));
        end else if (r < 83) begin
            send_beat(OP_DEADLINE, 8'($urandom));
        end else if (r < 90) begin
            send_beat(OP_DATA, 8'($urandom));    // stray byte after the request
            send_beat(OP_CLOSE, 8'($urandom));
        end else if (r < 95) begin
            send_beat(OP_CLOSE, 8'($urandom));
            repeat ($urandom_range(1, 3)) send_beat(2'($urandom_range(2)), 8'($urandom));
        end
    endtask

    task automatic broken_header();
        string      s;
        int         k;
        logic [7:0] c;
        case ($urandom_range(7))
            0: begin    // one header character replaced
                s = $urandom_range(1) ? "STATUS\n" : normalize_line($urandom_range(12), 0);
                k = $urandom_range(s.len() - 2);
                s[k] = 8'($urandom_range(8'h20, 8'h7E));
                send_str(s);
                repeat ($urandom_range(6)) send_beat(OP_DATA, random_text_byte(1'b0));
            end
            1: send_str("NORMALIZE \n");    // no count at all
            2: begin    // non-digit inside the count
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c >= "0" && c <= "9") c = "x";
                s = {"NORMALIZE ", $sformatf("%0d", $urandom_range(99))};
                s = {s, " ", $sformatf("%0d\n", $urandom_range(9))};
                s[s.len() - 3] = c;
                send_str(s);
            end
            3: begin    // count around and far over the payload maximum
                k = $urandom_range(3) == 0 ? 99999 : $urandom_range(PAYLOAD_MAX - 2,
                                                                   PAYLOAD_MAX + 60);
                send_str(normalize_line(k, 0));
            end
            4: begin    // line length around the header limit
                k = $urandom_range(HDR_LIMIT - 4, HDR_LIMIT + 8);
                s = "NORMALIZE ";
                while (s.len() < k - 1) s = {s, "0"};
                send_str({s, "7\n"});
                repeat (7) send_beat(OP_DATA, random_text_byte(1'b0));
            end
            5: begin    // non-printable byte in the header
                c = $urandom_range(1) ? 8'($urandom_range(8'h1F)) :
                                        8'($urandom_range(8'h7F, 8'hFF));
                if (c == CH_NL) c = 8'h0B;
                send_str("NORM");
                send_beat(OP_DATA, c);
            end
            6: begin
                case ($urandom_range(2))
                    0:       send_str("status\n");
                    1:       send_str("STATUSX\n");
                    default: send_str("STATU\n");
                endcase
            end
            default: begin    // request cut off inside the header
                send_str("NORMAL");
                send_beat($urandom_range(1) ? OP_CLOSE : OP_DEADLINE, 8'($urandom));
            end
        endcase
        end_session();
    endtask

    task automatic run_session();
        int n;
        int zeros;
        int kind;
        bit ctrl_ok;
        if ($urandom_range(9) != 0) send_beat(OP_CONNECT, 8'($urandom));
        kind = $urandom_range(99);
        if (kind < 10) begin
            send_str("STATUS\n");
            end_session();
        end else if (kind < 60) begin
            n       = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24);
            zeros   = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
            ctrl_ok = ($urandom_range(5) == 0);
            send_str(normalize_line(n, zeros));
            repeat (n) send_beat(OP_DATA, random_text_byte(ctrl_ok));
            end_session();
        end else if (kind < 75) begin
            broken_header();
        end else if (kind < 85) begin
            // payload cut short by close, deadline or a new connection
            n = $urandom_range(2, 24);
            send_str(normalize_line(n, 0));
            repeat ($urandom_range(n - 1)) send_beat(OP_DATA, random_text_byte(1'b0));
            send_beat(2'($urandom_range(1, 3)), 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 8)) send_beat(2'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void report_mismatch(input string why, input t_result want,
                                            input t_result seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: expected kind=%0d text=%h code=%0d count=%0d len=%0d last=%0d",
                     $time, why, want.kind, want.text, want.code, want.count, want.len,
                     want.last);
            $display("%0t %s:      got kind=%0d text=%h code=%0d count=%0d len=%0d last=%0d",
                     $time, why, seen.kind, seen.text, seen.code, seen.count, seen.len,
                     seen.last);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen.kind  = o_item_kind;
            seen.text  = o_text_byte;
            seen.code  = o_reply_code;
            seen.count = o_completed_count;
            seen.len   = o_output_length;
            seen.last  = o_last_item;
            if (due_items.size() == 0) begin
                report_mismatch("beat with nothing expected", '0, seen);
            end else begin
                want = due_items.pop_front();
                if (seen.kind !== want.kind || seen.text !== want.text ||
                    seen.code !== want.code || seen.count !== want.count ||
                    seen.len !== want.len || seen.last !== want.last) begin
                    report_mismatch("result mismatch", want, seen);
                end
            end
        end
    end

    // no beat on either side for too long means the block hung
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int  idle_phase;
        open_connection();
        ok_count = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            send_beat(DIRECTED[k].op, DIRECTED[k].b, DIRECTED[k].typed, DIRECTED[k].code);
        end

        while (beats_counted < TARGET_BEATS) begin
            // flow-control phases: none, sender gaps, receiver stalls, light both
            idle_phase = beats_counted * 4 / TARGET_BEATS;
            case (idle_phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 61; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 61; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            run_session();
        end

        i_valid <= 1'b0;
        while (due_items.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/rftn_pkg.sv
design/rftn_parser.sv
design/rftn_outq.sv
design/request_framer_text_normalizer.sv
design/rftn_checker.sv
test/tb_request_framer_text_normalizer.sv
